// ===== hw/rtl/sdh_pkg.sv =====
`timescale 1ns / 1ps
package sdh_pkg;
    localparam int HASH_SLOTS_DEF  = 1024;
    localparam int ENTRY_CAP_DEF   = 768;
    localparam int STORE_BYTES_DEF = 16384;
    localparam int MAX_KEY_LEN_DEF = 258;
    localparam int KEY_W   = 8;
    localparam int IDX_W   = 10;
    localparam int STAT_W  = 2;
    localparam int HITS_W  = 16;
    localparam int HASH_W  = 32;
    localparam logic [HASH_W-1:0] HASH_MUL = 32'd111;
    localparam logic [HITS_W-1:0] HITS_MAX = 16'hFFFF;

    localparam logic [STAT_W-1:0] ST_ADDED    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FOUND    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,      // sweep slot table to empty after reset
        S_IDLE,       // accept key bytes
        S_PROBE_RD,   // issue slot read
        S_PROBE_CHK,  // inspect slot
        S_ENT_CHK,    // inspect entry length/offset
        S_CMP_RD,     // issue byte reads
        S_CMP_CHK,    // compare one byte pair
        S_HIT,        // bump hit count
        S_ADD,        // write new entry
        S_OUT         // present result
    } t_state;
endpackage

// ===== hw/rtl/sdh_if.sv =====
`timescale 1ns / 1ps
interface sdh_in_if;
    import sdh_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_byte;
    logic             last_byte;
    modport source (output valid, key_byte, last_byte, input ready);
    modport sink   (input valid, key_byte, last_byte, output ready);
endinterface

interface sdh_out_if;
    import sdh_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  entry_index;
    logic [STAT_W-1:0] status;
    logic [HITS_W-1:0] hit_count;
    modport source (output valid, entry_index, status, hit_count, input ready);
    modport sink   (input valid, entry_index, status, hit_count, output ready);
endinterface

// ===== hw/rtl/string_dictionary_hash_insert_top.sv =====
`timescale 1ns / 1ps
// Key interning dictionary. A key enters one byte per item (tag high, tag
// low, name bytes; last_byte marks the end), and a running hash h*111+byte
// is built as the bytes are taken; the multiply by 111 is a shift-and-add.
// At the key end a sequencer probes the slot table linearly and, for each
// occupied slot whose entry length equals the key length, compares stored
// bytes pair by pair over the single byte-store read port. After the last
// byte, a key whose home slot is empty passes probe read, probe check, add
// and result; each occupied slot passed adds a read, a check and an entry
// fetch, plus two reads and a check per byte compared, and a hit ends with
// an update state and the result state. Overlong keys and keys that do not
// fit the store go straight to the result state. The result item holds
// until taken, and the next key is not accepted before that. After reset
// the slot table is swept clear, one slot per cycle, during which no item
// is accepted.
// HASH_SLOTS must be a power of two. Status: 0 added, 1 found, 2 full,
// 3 key too long; entry_index and hit_count are 0 on errors.
module string_dictionary_hash_insert_top
    import sdh_pkg::*;
#(
    parameter int HASH_SLOTS  = HASH_SLOTS_DEF,
    parameter int ENTRY_CAP   = ENTRY_CAP_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sdh_in_if.sink    i_key,
    sdh_out_if.source o_res
);
    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int ENT_W  = $clog2(ENTRY_CAP);
    localparam int ENTC_W = $clog2(ENTRY_CAP + 1);
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int FILL_W = $clog2(STORE_BYTES + 1);
    localparam int LEN_W  = $clog2(MAX_KEY_LEN + 1);
    localparam int PRB_W  = $clog2(HASH_SLOTS + 1);
    localparam int SLOTV_W = $clog2(ENTRY_CAP + 1);
    // Wide enough for fill + len + 1 without wrap.
    localparam int SUM_W  = FILL_W + 1;

    t_state r_state, n_state;

    logic [HASH_W-1:0] r_hash;
    logic [LEN_W-1:0]  r_len;
    logic              r_ovf;
    logic [ENTC_W-1:0] r_count;
    logic [FILL_W-1:0] r_fill;
    logic [SLOT_W-1:0] r_slot;
    logic [PRB_W-1:0]  r_probes;
    logic [ENT_W-1:0]  r_ent;
    logic [LEN_W-1:0]  r_k;
    logic [ADDR_W-1:0] r_eoff;
    logic [IDX_W-1:0]  r_o_idx;
    logic [STAT_W-1:0] r_o_st;
    logic [HITS_W-1:0] r_o_hits;
    logic              r_cmp_phase;   // byte reads alternate: stored, then new
    logic [KEY_W-1:0]  r_byte_a;

    // Memory ports
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr, slot_raddr;
    logic [SLOTV_W-1:0] slot_wdata, slot_rdata;
    logic              byte_we;
    logic [ADDR_W-1:0] byte_waddr, byte_raddr;
    logic [KEY_W-1:0]  byte_wdata, byte_rdata;
    logic              ent_we;
    logic [ENT_W-1:0]  ent_waddr, ent_raddr, hit_waddr;
    logic [ADDR_W-1:0] off_rdata;
    logic [LEN_W-1:0]  len_rdata;
    logic              hit_we;
    logic [HITS_W-1:0] hit_wdata, hit_rdata;

    sdh_ram #(.WIDTH(SLOTV_W), .DEPTH(HASH_SLOTS)) u_slot (
        .i_clk, .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(slot_raddr), .o_rdata(slot_rdata));
    sdh_ram #(.WIDTH(KEY_W), .DEPTH(STORE_BYTES)) u_bytes (
        .i_clk, .i_we(byte_we), .i_waddr(byte_waddr), .i_wdata(byte_wdata),
        .i_raddr(byte_raddr), .o_rdata(byte_rdata));
    sdh_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRY_CAP)) u_off (
        .i_clk, .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(r_fill[ADDR_W-1:0]),
        .i_raddr(ent_raddr), .o_rdata(off_rdata));
    sdh_ram #(.WIDTH(LEN_W), .DEPTH(ENTRY_CAP)) u_len (
        .i_clk, .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(r_len),
        .i_raddr(ent_raddr), .o_rdata(len_rdata));
    sdh_ram #(.WIDTH(HITS_W), .DEPTH(ENTRY_CAP)) u_hits (
        .i_clk, .i_we(hit_we), .i_waddr(hit_waddr), .i_wdata(hit_wdata),
        .i_raddr(ent_raddr), .o_rdata(hit_rdata));

    logic in_acc, byte_ok, store_pos_ok, add_ok;
    logic [SUM_W-1:0] pos_full, end_sum;
    logic [SLOTV_W-1:0] slot_ent1;
    logic [SUM_W-1:0] a_addr, b_addr;
    logic [HASH_W-1:0] hash_next;

    assign in_acc   = i_key.valid && i_key.ready;
    assign byte_ok  = (r_len < LEN_W'(MAX_KEY_LEN));
    assign pos_full = SUM_W'(r_fill) + SUM_W'(r_len);
    assign store_pos_ok = (pos_full < SUM_W'(STORE_BYTES));
    assign end_sum  = pos_full;   // fill + key length
    assign slot_ent1 = slot_rdata - SLOTV_W'(1);
    assign a_addr   = SUM_W'(r_eoff) + SUM_W'(r_k);
    assign b_addr   = SUM_W'(r_fill) + SUM_W'(r_k);
    // Fetch the entry fields for the slot under inspection during the probe check, ready for the entry check.
    assign ent_raddr = (r_state == S_PROBE_CHK) ? slot_ent1[ENT_W-1:0] : r_ent;
    // A new entry needs an empty slot, a free entry and room for the terminator.
    assign add_ok   = (r_probes != PRB_W'(HASH_SLOTS)) &&
                      (r_count < ENTC_W'(ENTRY_CAP)) && store_pos_ok;
    // Drop bytes past the length limit from the hash.
    assign hash_next = byte_ok ? (r_hash << 6) + (r_hash << 5) + (r_hash << 3)
                                 + (r_hash << 2) + (r_hash << 1) + r_hash
                                 + HASH_W'(i_key.key_byte)
                               : r_hash;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:     if (r_slot == SLOT_W'(HASH_SLOTS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc && i_key.last_byte) begin
                    if (r_ovf || !byte_ok) begin
                        n_state = S_OUT;
                    end else if (end_sum + SUM_W'(1) > SUM_W'(STORE_BYTES)) begin
                        // key bytes, this one included, must fit the store
                        n_state = S_OUT;
                    end else begin
                        n_state = S_PROBE_RD;
                    end
                end
            end
            S_PROBE_RD:  n_state = S_PROBE_CHK;
            S_PROBE_CHK: begin
                if (r_probes == PRB_W'(HASH_SLOTS) || slot_rdata == '0) begin
                    n_state = S_ADD;
                end else if (ENTC_W'(slot_ent1) < r_count) begin
                    n_state = S_ENT_CHK;
                end else begin
                    n_state = S_PROBE_RD;
                end
            end
            S_ENT_CHK: begin
                if (len_rdata != r_len) n_state = S_PROBE_RD;
                else if (r_len == '0)  n_state = S_HIT;
                else                   n_state = S_CMP_RD;
            end
            S_CMP_RD:    n_state = r_cmp_phase ? S_CMP_CHK : S_CMP_RD;
            S_CMP_CHK: begin
                if (a_addr >= SUM_W'(STORE_BYTES) || byte_rdata != r_byte_a) begin
                    n_state = S_PROBE_RD;
                end else if (r_k == r_len - LEN_W'(1)) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_HIT:       n_state = S_OUT;
            S_ADD:       n_state = S_OUT;
            S_OUT:       if (o_res.ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs and memory controls
    always_comb begin
        i_key.ready = (r_state == S_IDLE);
        o_res.valid = (r_state == S_OUT);
        o_res.entry_index = r_o_idx;
        o_res.status      = r_o_st;
        o_res.hit_count   = r_o_hits;
        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = '0;
        slot_raddr = r_slot;
        byte_we    = 1'b0;
        byte_waddr = pos_full[ADDR_W-1:0];
        byte_wdata = i_key.key_byte;
        byte_raddr = r_cmp_phase ? b_addr[ADDR_W-1:0] : a_addr[ADDR_W-1:0];
        ent_we     = 1'b0;
        ent_waddr  = r_count[ENT_W-1:0];
        hit_we     = 1'b0;
        hit_waddr  = r_ent;
        hit_wdata  = (hit_rdata == HITS_MAX) ? HITS_MAX : hit_rdata + HITS_W'(1);
        case (r_state)
            S_CLEAR: slot_we = 1'b1;
            S_IDLE:  byte_we = in_acc && byte_ok && store_pos_ok;
            S_HIT:   hit_we = 1'b1;
            S_ADD: begin
                if (add_ok) begin
                    slot_we    = 1'b1;
                    slot_wdata = SLOTV_W'(r_count) + SLOTV_W'(1);
                    ent_we     = 1'b1;
                    byte_we    = 1'b1;
                    byte_wdata = '0;
                    hit_we     = 1'b1;
                    hit_waddr  = r_count[ENT_W-1:0];
                    hit_wdata  = HITS_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_hash  <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_count <= '0;
            r_fill  <= '0;
            r_slot  <= '0;
            r_probes <= '0;
            r_cmp_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_slot <= r_slot + SLOT_W'(1);
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_key.last_byte) begin
                            r_hash   <= '0;
                            r_probes <= '0;
                            r_slot   <= hash_next[SLOT_W-1:0];
                            r_o_idx  <= '0;
                            r_o_hits <= '0;
                            if (r_ovf || !byte_ok) begin
                                r_o_st <= ST_TOO_LONG;
                                r_len  <= '0;
                                r_ovf  <= 1'b0;
                            end else begin
                                r_o_st <= ST_FULL;
                                if (end_sum + SUM_W'(1) > SUM_W'(STORE_BYTES))
                                    r_len <= '0;
                                else
                                    r_len <= r_len + LEN_W'(1);
                            end
                        end else begin
                            r_hash <= hash_next;
                            if (byte_ok) r_len <= r_len + LEN_W'(1);
                            else r_ovf <= 1'b1;
                        end
                    end
                end
                S_PROBE_CHK: begin
                    r_ent <= slot_ent1[ENT_W-1:0];
                    if (!(r_probes == PRB_W'(HASH_SLOTS) || slot_rdata == '0) &&
                        !(ENTC_W'(slot_ent1) < r_count)) begin
                        r_slot   <= r_slot + SLOT_W'(1);
                        r_probes <= r_probes + PRB_W'(1);
                    end
                end
                S_ENT_CHK: begin
                    r_eoff <= off_rdata;
                    r_k    <= '0;
                    r_cmp_phase <= 1'b0;
                    if (len_rdata != r_len) begin
                        r_slot   <= r_slot + SLOT_W'(1);
                        r_probes <= r_probes + PRB_W'(1);
                    end
                end
                S_CMP_RD: begin
                    if (r_cmp_phase) r_byte_a <= byte_rdata;
                    r_cmp_phase <= !r_cmp_phase;
                end
                S_CMP_CHK: begin
                    r_cmp_phase <= 1'b0;
                    r_k <= r_k + LEN_W'(1);
                    if (a_addr >= SUM_W'(STORE_BYTES) || byte_rdata != r_byte_a) begin
                        r_slot   <= r_slot + SLOT_W'(1);
                        r_probes <= r_probes + PRB_W'(1);
                    end
                end
                S_HIT: begin
                    r_o_idx  <= IDX_W'(r_ent);
                    r_o_st   <= ST_FOUND;
                    r_o_hits <= hit_wdata;
                    r_len    <= '0;
                end
                S_ADD: begin
                    if (add_ok) begin
                        r_o_idx  <= IDX_W'(r_count);
                        r_o_st   <= ST_ADDED;
                        r_o_hits <= HITS_W'(1);
                        r_count  <= r_count + ENTC_W'(1);
                        r_fill   <= FILL_W'(end_sum + SUM_W'(1));
                    end
                    r_len <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hw/rtl/sdh_ram.sv =====
`timescale 1ns / 1ps
module sdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule
